@@ rtl/core/gbrc_pkg.sv @@
// Package for the gamepad button remap crossbar: item types, button and hat codes.
`default_nettype none
package gbrc_pkg;

  localparam int NUM_BUTTONS = 19;
  localparam int IDX_W       = 5;
  localparam int MASK_W      = 32;

  // Operation codes
  localparam logic OP_APPLY = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Button numbers, also the bit order of every mask
  localparam int BTN_L2    = 6;
  localparam int BTN_R2    = 7;
  localparam int BTN_UP    = 15;
  localparam int BTN_RIGHT = 16;
  localparam int BTN_DOWN  = 17;
  localparam int BTN_LEFT  = 18;

  // Hat codes
  localparam logic [3:0] HAT_UP         = 4'd0;
  localparam logic [3:0] HAT_UP_RIGHT   = 4'd1;
  localparam logic [3:0] HAT_RIGHT      = 4'd2;
  localparam logic [3:0] HAT_DOWN_RIGHT = 4'd3;
  localparam logic [3:0] HAT_DOWN       = 4'd4;
  localparam logic [3:0] HAT_DOWN_LEFT  = 4'd5;
  localparam logic [3:0] HAT_LEFT       = 4'd6;
  localparam logic [3:0] HAT_UP_LEFT    = 4'd7;
  localparam logic [3:0] HAT_NONE       = 4'd8;

  localparam logic [7:0] ANALOG_FULL = 8'hFF;

  typedef logic [NUM_BUTTONS-1:0] btn_mask_t;

  typedef struct packed {
    logic              op;
    logic [7:0]        l2_analog;
    logic [7:0]        r2_analog;
    logic [7:0]        hat_face_byte;
    logic [7:0]        shoulder_byte;
    logic [7:0]        system_byte;
    logic [IDX_W-1:0]  entry_index;
    logic [MASK_W-1:0] entry_mask;
  } in_item_t;

  typedef struct packed {
    logic [7:0] l2_out;
    logic [7:0] r2_out;
    logic [7:0] hat_face_out;
    logic [7:0] shoulder_out;
    logic [7:0] system_out;
    logic       write_ok;
  } out_item_t;

endpackage
`default_nettype wire

@@ rtl/core/gamepad_button_remap_crossbar.sv @@
// Top level of the gamepad button remap crossbar: table, remap logic and result register.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_ready   | in_item  (gbrc_pkg::in_item_t)
//   out     | output    | out_valid / out_ready | out_item (gbrc_pkg::out_item_t)
//
// The crossbar OR and trigger max sit between the accepted item and the result
// register, so one item is accepted per cycle unless a stalled result holds in_ready low.
// A write updates the table at its accept edge; the next item already sees it.
// Reset (rst, synchronous) loads the identity table and empties the result register.
// A stalled result holds; in_ready drops only while a result waits and out_ready is low.
`default_nettype none
module gamepad_button_remap_crossbar (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire gbrc_pkg::in_item_t   in_item,
  output logic                      out_valid,
  input  wire                       out_ready,
  output gbrc_pkg::out_item_t       out_item
);
  import gbrc_pkg::*;

  btn_mask_t  target_table [NUM_BUTTONS];
  btn_mask_t  target_table_next [NUM_BUTTONS];
  logic       identity_flag;
  logic       identity_flag_next;

  logic       accept;
  logic       write_ok_c;
  btn_mask_t  src;
  btn_mask_t  dst;
  logic [3:0] hat_in;
  logic [3:0] hat_out;
  logic       up, right, down, left;
  logic       l2_full, r2_full;
  logic [7:0] l2_a, l2_b, r2_a, r2_b;
  out_item_t  result;

  function automatic logic [7:0] max8(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a : b;
  endfunction

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign write_ok_c = (in_item.entry_index < IDX_W'(NUM_BUTTONS)) &&
                      (in_item.entry_mask[MASK_W-1:NUM_BUTTONS] == '0);

  // Table update and identity recompute
  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      target_table_next[i] = target_table[i];
      if (accept && in_item.op == OP_WRITE && write_ok_c &&
          in_item.entry_index == IDX_W'(i)) begin
        target_table_next[i] = in_item.entry_mask[NUM_BUTTONS-1:0];
      end
    end
    identity_flag_next = 1'b1;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (target_table_next[i] != (btn_mask_t'(1) << i)) begin
        identity_flag_next = 1'b0;
      end
    end
  end

  // Pressed sources, hat directions decoded
  always_comb begin
    hat_in = in_item.hat_face_byte[3:0];
    src = '0;
    src[3:0]   = in_item.hat_face_byte[7:4];
    src[11:4]  = in_item.shoulder_byte;
    src[14:12] = in_item.system_byte[2:0];
    src[BTN_UP]    = (hat_in == HAT_UP) || (hat_in == HAT_UP_RIGHT) ||
                     (hat_in == HAT_UP_LEFT);
    src[BTN_RIGHT] = (hat_in == HAT_UP_RIGHT) || (hat_in == HAT_RIGHT) ||
                     (hat_in == HAT_DOWN_RIGHT);
    src[BTN_DOWN]  = (hat_in == HAT_DOWN_RIGHT) || (hat_in == HAT_DOWN) ||
                     (hat_in == HAT_DOWN_LEFT);
    src[BTN_LEFT]  = (hat_in == HAT_DOWN_LEFT) || (hat_in == HAT_LEFT) ||
                     (hat_in == HAT_UP_LEFT);
  end

  // Crossbar OR; any non-trigger source that lands on a trigger drives it full
  always_comb begin
    dst     = '0;
    l2_full = 1'b0;
    r2_full = 1'b0;
    for (int s = 0; s < NUM_BUTTONS; s++) begin
      if (src[s]) begin
        dst = dst | target_table[s];
        if (s != BTN_L2 && s != BTN_R2) begin
          l2_full = l2_full | target_table[s][BTN_L2];
          r2_full = r2_full | target_table[s][BTN_R2];
        end
      end
    end
    l2_a = (src[BTN_L2] && target_table[BTN_L2][BTN_L2]) ? in_item.l2_analog : 8'd0;
    l2_b = (src[BTN_R2] && target_table[BTN_R2][BTN_L2]) ? in_item.r2_analog : 8'd0;
    r2_a = (src[BTN_L2] && target_table[BTN_L2][BTN_R2]) ? in_item.l2_analog : 8'd0;
    r2_b = (src[BTN_R2] && target_table[BTN_R2][BTN_R2]) ? in_item.r2_analog : 8'd0;
  end

  // Rebuild the hat; opposite directions cancel
  always_comb begin
    up    = dst[BTN_UP] && !dst[BTN_DOWN];
    down  = dst[BTN_DOWN] && !dst[BTN_UP];
    right = dst[BTN_RIGHT] && !dst[BTN_LEFT];
    left  = dst[BTN_LEFT] && !dst[BTN_RIGHT];
    if (up) begin
      hat_out = right ? HAT_UP_RIGHT : (left ? HAT_UP_LEFT : HAT_UP);
    end else if (down) begin
      hat_out = right ? HAT_DOWN_RIGHT : (left ? HAT_DOWN_LEFT : HAT_DOWN);
    end else if (right) begin
      hat_out = HAT_RIGHT;
    end else if (left) begin
      hat_out = HAT_LEFT;
    end else begin
      hat_out = HAT_NONE;
    end
  end

  always_comb begin
    result = '0;
    if (in_item.op == OP_WRITE) begin
      result.write_ok = write_ok_c;
    end else if (identity_flag) begin
      result.l2_out       = in_item.l2_analog;
      result.r2_out       = in_item.r2_analog;
      result.hat_face_out = in_item.hat_face_byte;
      result.shoulder_out = in_item.shoulder_byte;
      result.system_out   = in_item.system_byte;
    end else begin
      result.l2_out       = l2_full ? ANALOG_FULL : max8(l2_a, l2_b);
      result.r2_out       = r2_full ? ANALOG_FULL : max8(r2_a, r2_b);
      result.hat_face_out = {dst[3:0], hat_out};
      result.shoulder_out = dst[11:4];
      result.system_out   = {in_item.system_byte[7:3], dst[14:12]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        target_table[i] <= btn_mask_t'(1) << i;
      end
      identity_flag <= 1'b1;
      out_valid     <= 1'b0;
    end else begin
      target_table  <= target_table_next;
      identity_flag <= identity_flag_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the result on accept, otherwise hold
  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= result;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/gbrc_checker.sv @@
// Port checker for the gamepad button remap crossbar, bound to the top level.
`default_nettype none
module gbrc_checker (
  input wire                       clk,
  input wire                       rst,
  input wire                       in_valid,
  input wire                       in_ready,
  input wire gbrc_pkg::in_item_t   in_item,
  input wire                       out_valid,
  input wire                       out_ready,
  input wire gbrc_pkg::out_item_t  out_item
);
  import gbrc_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed or dropped");

  // Empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty result register");

  // Apply items and rejected writes never report write_ok
  a_no_ok: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready &&
    (in_item.op == OP_APPLY || in_item.entry_index >= IDX_W'(NUM_BUTTONS) ||
     in_item.entry_mask[MASK_W-1:NUM_BUTTONS] != '0)
    |=> out_valid && !out_item.write_ok)
    else $error("write_ok set for apply or rejected write");

  // A write result carries zero report bytes
  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.write_ok |->
    out_item.l2_out == 8'd0 && out_item.r2_out == 8'd0 &&
    out_item.hat_face_out == 8'd0 && out_item.shoulder_out == 8'd0 &&
    out_item.system_out == 8'd0)
    else $error("write result with nonzero report bytes");

endmodule

bind gamepad_button_remap_crossbar gbrc_checker u_gbrc_checker (.*);
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the gamepad button remap crossbar.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gbrc_pkg::*;

  localparam int TOTAL_ITEMS     = 750;
  localparam int IDLE_LIMIT      = 2000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int HOLD_OFF_AFTER  = 150;
  localparam int PRINT_LIMIT     = 50;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } step_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  btn_mask_t   remap_table [NUM_BUTTONS];
  out_item_t   pending_reports [$];
  step_row_t   directed_rows [$];
  int          n_items = 0;
  int          n_writes = 0;
  int          n_rejected = 0;
  int          n_passthrough = 0;
  int          n_results = 0;
  int          n_mismatches = 0;
  int          idle_cycles = 0;

  gamepad_button_remap_crossbar u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always #1 clk = ~clk;

  function automatic bit table_is_identity();
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (remap_table[i] != btn_mask_t'(1) << i) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Expected result of one item; a write also updates the table copy.
  function automatic out_item_t predict_remap(input in_item_t it);
    out_item_t  r;
    btn_mask_t  pressed;
    btn_mask_t  routed;
    btn_mask_t  tgt;
    logic [7:0] val;
    logic [3:0] hat;
    logic       up, rt, dn, lf;
    r = '0;
    if (it.op == OP_WRITE) begin
      if (it.entry_index < NUM_BUTTONS && it.entry_mask[MASK_W-1:NUM_BUTTONS] == '0) begin
        remap_table[it.entry_index] = it.entry_mask[NUM_BUTTONS-1:0];
        r.write_ok = 1'b1;
      end
      return r;
    end
    if (table_is_identity()) begin
      r.l2_out       = it.l2_analog;
      r.r2_out       = it.r2_analog;
      r.hat_face_out = it.hat_face_byte;
      r.shoulder_out = it.shoulder_byte;
      r.system_out   = it.system_byte;
      return r;
    end
    pressed = '0;
    pressed[3:0]   = it.hat_face_byte[7:4];
    pressed[11:4]  = it.shoulder_byte;
    pressed[14:12] = it.system_byte[2:0];
    case (it.hat_face_byte[3:0])
      HAT_UP:         pressed[BTN_UP] = 1'b1;
      HAT_UP_RIGHT:   begin pressed[BTN_UP] = 1'b1; pressed[BTN_RIGHT] = 1'b1; end
      HAT_RIGHT:      pressed[BTN_RIGHT] = 1'b1;
      HAT_DOWN_RIGHT: begin pressed[BTN_DOWN] = 1'b1; pressed[BTN_RIGHT] = 1'b1; end
      HAT_DOWN:       pressed[BTN_DOWN] = 1'b1;
      HAT_DOWN_LEFT:  begin pressed[BTN_DOWN] = 1'b1; pressed[BTN_LEFT] = 1'b1; end
      HAT_LEFT:       pressed[BTN_LEFT] = 1'b1;
      HAT_UP_LEFT:    begin pressed[BTN_UP] = 1'b1; pressed[BTN_LEFT] = 1'b1; end
      default:        ;
    endcase
    routed = '0;
    for (int s = 0; s < NUM_BUTTONS; s++) begin
      if (pressed[s]) begin
        tgt = remap_table[s];
        routed |= tgt;
        // trigger sources carry their own analog, any other button counts as full
        val = (s == BTN_L2) ? it.l2_analog : ((s == BTN_R2) ? it.r2_analog : ANALOG_FULL);
        if (tgt[BTN_L2] && val > r.l2_out) r.l2_out = val;
        if (tgt[BTN_R2] && val > r.r2_out) r.r2_out = val;
      end
    end
    up = routed[BTN_UP];
    rt = routed[BTN_RIGHT];
    dn = routed[BTN_DOWN];
    lf = routed[BTN_LEFT];
    if (up && dn) begin
      up = 1'b0;
      dn = 1'b0;
    end
    if (lf && rt) begin
      lf = 1'b0;
      rt = 1'b0;
    end
    if (up) hat = rt ? HAT_UP_RIGHT : (lf ? HAT_UP_LEFT : HAT_UP);
    else if (dn) hat = rt ? HAT_DOWN_RIGHT : (lf ? HAT_DOWN_LEFT : HAT_DOWN);
    else if (rt) hat = HAT_RIGHT;
    else if (lf) hat = HAT_LEFT;
    else hat = HAT_NONE;
    r.hat_face_out = {routed[3:0], hat};
    r.shoulder_out = routed[11:4];
    r.system_out   = {it.system_byte[7:3], routed[14:12]};
    return r;
  endfunction

  function automatic in_item_t apply_item(input logic [7:0] l2, r2, hf, sh, sy);
    in_item_t it;
    it.op            = OP_APPLY;
    it.l2_analog     = l2;
    it.r2_analog     = r2;
    it.hat_face_byte = hf;
    it.shoulder_byte = sh;
    it.system_byte   = sy;
    it.entry_index   = IDX_W'($urandom);
    it.entry_mask    = $urandom;
    return it;
  endfunction

  function automatic in_item_t write_item(input logic [IDX_W-1:0] idx,
                                          input logic [MASK_W-1:0] mask);
    in_item_t it;
    it.op            = OP_WRITE;
    it.l2_analog     = 8'($urandom);
    it.r2_analog     = 8'($urandom);
    it.hat_face_byte = 8'($urandom);
    it.shoulder_byte = 8'($urandom);
    it.system_byte   = 8'($urandom);
    it.entry_index   = idx;
    it.entry_mask    = mask;
    return it;
  endfunction

  function automatic out_item_t report_out(input logic [7:0] l2, r2, hf, sh, sy,
                                           input logic ok);
    out_item_t r;
    r.l2_out       = l2;
    r.r2_out       = r2;
    r.hat_face_out = hf;
    r.shoulder_out = sh;
    r.system_out   = sy;
    r.write_ok     = ok;
    return r;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a run with none.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic add_row(input in_item_t it, input bit typed, input out_item_t want);
    step_row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  int send_calm = 0;

  // Offer one item and hold it until accepted, then queue its expected result.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    int        gap;
    out_item_t predicted;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (it.op == OP_APPLY && table_is_identity()) n_passthrough++;
    predicted = predict_remap(it);
    if (it.op == OP_WRITE) begin
      n_writes++;
      if (!predicted.write_ok) n_rejected++;
    end
    pending_reports.push_back(typed ? want : predicted);
    n_items++;
  endtask

  task automatic restore_identity();
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      send_item(write_item(IDX_W'(b), 32'd1 << b), 1'b0, '0);
    end
  endtask

  task automatic report_mismatch(input string msg);
    n_mismatches++;
    if (n_mismatches <= PRINT_LIMIT) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%02h, expected 0x%02h", name, got, want));
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (pending_reports.size() == 0) begin
        report_mismatch("result arrived with nothing expected");
      end else begin
        want = pending_reports.pop_front();
        check_field("l2_out", out_item.l2_out, want.l2_out);
        check_field("r2_out", out_item.r2_out, want.r2_out);
        check_field("hat_face_out", out_item.hat_face_out, want.hat_face_out);
        check_field("shoulder_out", out_item.shoulder_out, want.shoulder_out);
        check_field("system_out", out_item.system_out, want.system_out);
        check_field("write_ok", {7'd0, out_item.write_ok}, {7'd0, want.write_ok});
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end else if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  initial begin : drive_out_ready
    int  gap;
    int  calm;
    bit  held;
    calm = 0;
    held = 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (!held && n_results >= HOLD_OFF_AFTER) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      gap = pick_gap(calm);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : stimulus
    out_item_t accepted;
    out_item_t rejected;
    int        pick;
    int        idx;
    logic [MASK_W-1:0] mask;
    for (int i = 0; i < NUM_BUTTONS; i++) remap_table[i] = btn_mask_t'(1) << i;
    accepted = report_out(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    rejected = report_out(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);

    // identity table: reports pass untouched, odd hat codes included
    add_row(apply_item(8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF), 1'b1,
            report_out(8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0));
    add_row(apply_item(8'h80, 8'h7F, 8'h3A, 8'h5A, 8'hA5), 1'b1,
            report_out(8'h80, 8'h7F, 8'h3A, 8'h5A, 8'hA5, 1'b0));
    // rejected writes: stray mask bits, index out of range
    add_row(write_item(5'd0, 32'h0008_0000), 1'b1, rejected);
    add_row(write_item(5'd5, 32'hFFFF_FFFF), 1'b1, rejected);
    add_row(write_item(5'd19, 32'h0000_0001), 1'b1, rejected);
    add_row(write_item(5'd31, 32'h0000_0000), 1'b1, rejected);
    // rewrite an entry with its own bit: table stays identity
    add_row(write_item(5'd3, 32'd1 << 3), 1'b1, accepted);
    add_row(apply_item(8'h11, 8'h22, 8'h0F, 8'h33, 8'hF4), 1'b1,
            report_out(8'h11, 8'h22, 8'h0F, 8'h33, 8'hF4, 1'b0));
    // square drives L2, L2 drives R2, R2 drives both triggers
    add_row(write_item(5'd0, 32'd1 << BTN_L2), 1'b1, accepted);
    add_row(apply_item(8'h12, 8'h34, 8'h18, 8'h00, 8'hF8), 1'b0, '0);
    add_row(write_item(5'(BTN_L2), 32'd1 << BTN_R2), 1'b1, accepted);
    add_row(write_item(5'(BTN_R2), (32'd1 << BTN_L2) | (32'd1 << BTN_R2)), 1'b1, accepted);
    add_row(apply_item(8'h40, 8'h90, 8'h08, 8'h0C, 8'h00), 1'b0, '0);
    add_row(apply_item(8'hFF, 8'hFF, 8'hFB, 8'hFF, 8'hFF), 1'b0, '0);
    // opposite directions cancel
    add_row(write_item(5'(BTN_UP), (32'd1 << BTN_UP) | (32'd1 << BTN_DOWN)), 1'b1, accepted);
    add_row(write_item(5'(BTN_RIGHT), (32'd1 << BTN_LEFT) | (32'd1 << BTN_RIGHT)), 1'b1,
            accepted);
    add_row(apply_item(8'h00, 8'h00, 8'h01, 8'h00, 8'h00), 1'b0, '0);
    add_row(write_item(5'(BTN_LEFT), 32'h0007_FFFF), 1'b1, accepted);
    add_row(write_item(5'd12, 32'h0000_0000), 1'b1, accepted);
    add_row(apply_item(8'h00, 8'h00, 8'hF6, 8'hFF, 8'hFF), 1'b0, '0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    restore_identity();
    while (n_items < TOTAL_ITEMS) begin
      pick = $urandom_range(0, 199);
      if (pick < 3) begin
        restore_identity();
      end else if (pick < 20) begin
        // invalid write: bad index or mask bits above the buttons
        if ($urandom_range(0, 1) == 0) begin
          idx  = $urandom_range(NUM_BUTTONS, 31);
          mask = $urandom;
        end else begin
          idx  = $urandom_range(0, NUM_BUTTONS - 1);
          mask = $urandom | (32'd1 << $urandom_range(NUM_BUTTONS, MASK_W - 1));
        end
        send_item(write_item(IDX_W'(idx), mask), 1'b0, '0);
      end else if (pick < 56) begin
        idx = $urandom_range(0, NUM_BUTTONS - 1);
        case ($urandom_range(0, 7))
          0, 1, 2: mask = 32'd1 << $urandom_range(0, NUM_BUTTONS - 1);
          3, 4:    mask = (32'd1 << $urandom_range(0, NUM_BUTTONS - 1))
                        | (32'd1 << $urandom_range(0, NUM_BUTTONS - 1));
          5, 6:    mask = $urandom & 32'h0007_FFFF;
          default: mask = '0;
        endcase
        send_item(write_item(IDX_W'(idx), mask), 1'b0, '0);
      end else begin
        mask = $urandom;
        // favor legal hat codes, keep some 9-15
        if ($urandom_range(0, 9) < 7) mask[3:0] = 4'($urandom_range(0, 8));
        send_item(apply_item(8'($urandom), 8'($urandom), mask[7:0], 8'($urandom),
                             8'($urandom)), 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d items: %0d table writes (%0d rejected), %0d identity passes",
             n_items, n_writes, n_rejected, n_passthrough);
    $display("%0d results compared, %0d field errors", n_results, n_mismatches);
    if (n_mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/core/gbrc_pkg.sv
rtl/core/gamepad_button_remap_crossbar.sv
rtl/core/gbrc_checker.sv
tb/sv/tb_top.sv
